[hw/rtl/ddpd_pkg.sv]
// Shared types, constants and saturation helpers for the differential drive PD controller.
// Used by the error stage, the drive stage and the top level; depends on nothing else.

package ddpd_pkg;

   // Fixed point scaling of the PD gains (Q8.8)
   localparam int unsigned GAIN_FRACTION_BITS = 8;

   // Configuration port geometry
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 24;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_DISTANCE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_ROTATION = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KP_TRANSLATION  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KD_TRANSLATION  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KP_ROTATION     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KD_ROTATION     = 3'd6;

   // Motor command limits
   localparam logic signed [15:0] DRIVE_MAX = 16'sd32767;
   localparam logic signed [15:0] DRIVE_MIN = -16'sd32767;

   // Errors handed from the error stage to the drive stage
   typedef struct packed {
      logic signed [31:0] trans_err;
      logic signed [32:0] trans_diff;
      logic signed [31:0] rot_err;
      logic signed [32:0] rot_diff;
   } err_type;

   // PD gains, all signed Q8.8
   typedef struct packed {
      logic signed [15:0] kp_trans;
      logic signed [15:0] kd_trans;
      logic signed [15:0] kp_rot;
      logic signed [15:0] kd_rot;
   } gain_type;

   // Clamp a 34-bit signed error to the signed 32-bit range
   function automatic logic signed [31:0] sat_err(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sh0_7FFF_FFFF;
      lo = -34'sh0_8000_0000;
      if (v > hi) begin
         sat_err = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat_err = 32'sh8000_0000;
      end else begin
         sat_err = v[31:0];
      end
   endfunction

   // Clamp a wide drive sum to the symmetric motor command range
   function automatic logic signed [15:0] sat_drive(input logic signed [50:0] v);
      logic signed [50:0] hi;
      logic signed [50:0] lo;
      hi = 51'(DRIVE_MAX);
      lo = 51'(DRIVE_MIN);
      if (v > hi) begin
         sat_drive = DRIVE_MAX;
      end else if (v < lo) begin
         sat_drive = DRIVE_MIN;
      end else begin
         sat_drive = v[15:0];
      end
   endfunction

endpackage

[hw/rtl/ddpd_error_stage.sv]
// Error stage: wheel deltas, running totals, translational and rotational errors.
// Holds the controller state registers; uses ddpd_pkg for types and saturation.

module ddpd_error_stage #(
   parameter int unsigned COUNTER_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    advance,
   input  logic [COUNTER_BITS-1:0] right_counter,
   input  logic [COUNTER_BITS-1:0] left_counter,
   input  logic signed [23:0]      target_distance,
   input  logic signed [15:0]      target_rotation,
   output logic                    err_valid,
   output ddpd_pkg::err_type       err
);

   logic [COUNTER_BITS-1:0] prev_right_ff, prev_right_in;
   logic [COUNTER_BITS-1:0] prev_left_ff, prev_left_in;
   logic signed [31:0]      total_right_ff, total_right_in;
   logic signed [31:0]      total_left_ff, total_left_in;
   logic signed [31:0]      prev_trans_ff, prev_trans_in;
   logic signed [31:0]      prev_rot_ff, prev_rot_in;
   logic                    valid_ff, valid_in;
   ddpd_pkg::err_type       err_ff, err_in;

   logic signed [COUNTER_BITS-1:0] delta_right;
   logic signed [COUNTER_BITS-1:0] delta_left;
   logic signed [32:0]             total_sum;
   logic signed [31:0]             half_sum;
   logic signed [33:0]             trans_wide;
   logic signed [33:0]             rot_wide;
   logic signed [33:0]             delta_gap;
   logic signed [31:0]             trans_err;
   logic signed [31:0]             rot_err;

   // Wrapped deltas, totals and saturated errors
   always_comb begin
      delta_right    = signed'(right_counter - prev_right_ff);
      delta_left     = signed'(left_counter - prev_left_ff);
      total_right_in = total_right_ff + 32'(delta_right);
      total_left_in  = total_left_ff + 32'(delta_left);
      total_sum      = 33'(total_right_in) + 33'(total_left_in);
      half_sum       = total_sum[32:1];
      trans_wide     = 34'(target_distance) - 34'(half_sum);
      delta_gap      = 34'(delta_right) - 34'(delta_left);
      rot_wide       = 34'(target_rotation) - delta_gap;
      trans_err      = ddpd_pkg::sat_err(trans_wide);
      rot_err        = ddpd_pkg::sat_err(rot_wide);

      prev_right_in = right_counter;
      prev_left_in  = left_counter;
      prev_trans_in = trans_err;
      prev_rot_in   = rot_err;

      err_in.trans_err  = trans_err;
      err_in.trans_diff = 33'(trans_err) - 33'(prev_trans_ff);
      err_in.rot_err    = rot_err;
      err_in.rot_diff   = 33'(rot_err) - 33'(prev_rot_ff);
   end

   // Fill on load, drain on advance
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Controller state: update only on an enabled tick
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_right_ff  <= '0;
         prev_left_ff   <= '0;
         total_right_ff <= '0;
         total_left_ff  <= '0;
         prev_trans_ff  <= '0;
         prev_rot_ff    <= '0;
         valid_ff       <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            prev_right_ff  <= prev_right_in;
            prev_left_ff   <= prev_left_in;
            total_right_ff <= total_right_in;
            total_left_ff  <= total_left_in;
            prev_trans_ff  <= prev_trans_in;
            prev_rot_ff    <= prev_rot_in;
         end
      end
   end

   // Error payload register
   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= err_in;
      end
   end

   assign err_valid = valid_ff;
   assign err       = err_ff;

endmodule

[hw/rtl/ddpd_drive_stage.sv]
// Drive stage: PD law on both errors, mixing into right/left drives, result register.
// Uses ddpd_pkg for the error and gain types, gain scaling and drive saturation.

module ddpd_drive_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               err_valid,
   input  ddpd_pkg::err_type  err,
   input  ddpd_pkg::gain_type gain,
   output logic               can_load,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_right_drive,
   output logic signed [15:0] rsp_left_drive
);

   logic signed [47:0] p_trans;
   logic signed [48:0] d_trans;
   logic signed [47:0] p_rot;
   logic signed [48:0] d_rot;
   logic signed [49:0] sum_trans;
   logic signed [49:0] sum_rot;
   logic signed [49:0] corr_trans;
   logic signed [49:0] corr_rot;
   logic signed [50:0] mix_right;
   logic signed [50:0] mix_left;

   logic               valid_ff, valid_in;
   logic signed [15:0] right_ff, right_in;
   logic signed [15:0] left_ff, left_in;
   logic               load;

   // PD products, scaling and mixing
   always_comb begin
      p_trans    = 48'(gain.kp_trans) * 48'(err.trans_err);
      d_trans    = 49'(gain.kd_trans) * 49'(err.trans_diff);
      p_rot      = 48'(gain.kp_rot) * 48'(err.rot_err);
      d_rot      = 49'(gain.kd_rot) * 49'(err.rot_diff);
      sum_trans  = 50'(p_trans) + 50'(d_trans);
      sum_rot    = 50'(p_rot) + 50'(d_rot);
      corr_trans = sum_trans >>> ddpd_pkg::GAIN_FRACTION_BITS;
      corr_rot   = sum_rot >>> ddpd_pkg::GAIN_FRACTION_BITS;
      mix_right  = 51'(corr_trans) + 51'(corr_rot);
      mix_left   = 51'(corr_trans) - 51'(corr_rot);
      right_in   = ddpd_pkg::sat_drive(mix_right);
      left_in    = ddpd_pkg::sat_drive(mix_left);
   end

   // Result register takes an item when empty or being drained
   assign can_load = !valid_ff || rsp_ready;
   assign load     = err_valid && can_load;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold drives until taken
   always_ff @(posedge clock) begin
      if (load) begin
         right_ff <= right_in;
         left_ff  <= left_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_left_drive  = left_ff;

endmodule

[hw/rtl/differential_drive_pd_controller.sv]
// Differential drive PD controller, two register stages: errors, then drives.
// Latency: 2 register stages; an enabled item's errors are registered first, then its
// drives on rsp_; the state loop closes inside the error stage.
// Throughput: one item per cycle while rsp_ready does not hold the result back.
// A tick accepted while disabled is consumed without a result or a state change.
// Reset clears the valid flags, enable, gains, targets and controller state to zero.
// Depends on ddpd_pkg, ddpd_error_stage and ddpd_drive_stage.

module differential_drive_pd_controller #(
   parameter int unsigned COUNTER_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [COUNTER_BITS-1:0]               req_right_counter,
   input  logic [COUNTER_BITS-1:0]               req_left_counter,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [15:0]                    rsp_right_drive,
   output logic signed [15:0]                    rsp_left_drive,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ddpd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   logic               enable_ff;
   logic signed [23:0] target_dist_ff;
   logic signed [15:0] target_rot_ff;
   ddpd_pkg::gain_type gain_ff;

   logic              err_valid;
   ddpd_pkg::err_type err;
   logic              can_load;
   logic              advance;
   logic              load;
   logic              csr_write;

   // Configuration registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         target_dist_ff <= '0;
         target_rot_ff  <= '0;
         gain_ff        <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ddpd_pkg::CSR_ENABLE:          enable_ff        <= csr_data[0];
            ddpd_pkg::CSR_TARGET_DISTANCE: target_dist_ff   <= csr_data[23:0];
            ddpd_pkg::CSR_TARGET_ROTATION: target_rot_ff    <= csr_data[15:0];
            ddpd_pkg::CSR_KP_TRANSLATION:  gain_ff.kp_trans <= csr_data[15:0];
            ddpd_pkg::CSR_KD_TRANSLATION:  gain_ff.kd_trans <= csr_data[15:0];
            ddpd_pkg::CSR_KP_ROTATION:     gain_ff.kp_rot   <= csr_data[15:0];
            ddpd_pkg::CSR_KD_ROTATION:     gain_ff.kd_rot   <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow: accept while the error stage is empty or moving on
   assign advance   = err_valid && can_load;
   assign req_ready = !err_valid || can_load;
   assign load      = req_valid && req_ready && enable_ff;

   ddpd_error_stage #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_error (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .advance         (advance),
      .right_counter   (req_right_counter),
      .left_counter    (req_left_counter),
      .target_distance (target_dist_ff),
      .target_rotation (target_rot_ff),
      .err_valid       (err_valid),
      .err             (err)
   );

   ddpd_drive_stage u_drive (
      .clock           (clock),
      .reset           (reset),
      .err_valid       (err_valid),
      .err             (err),
      .gain            (gain_ff),
      .can_load        (can_load),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_right_drive (rsp_right_drive),
      .rsp_left_drive  (rsp_left_drive)
   );

   // A disabled tick leaves the error stage empty
   a_disabled_drop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !enable_ff) |=> !err_valid)
      else $error("disabled item entered the error stage");

   // Input stalls only when both stages are full and the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (err_valid && rsp_valid && !rsp_ready))
      else $error("input stalled without a full pipeline");

   // Drives never reach the most negative code
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_drive != 16'sh8000 && rsp_left_drive != 16'sh8000))
      else $error("drive outside saturation range");

   // Enable follows a write to its register
   a_enable_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == ddpd_pkg::CSR_ENABLE) |=> (enable_ff == $past(csr_data[0])))
      else $error("enable register did not take the write");

endmodule

[bench/ddpd_drive_checker.sv]
`timescale 1ns / 1ps
// Drive command checker for the differential drive PD controller: predicts the drives of
// every tick taken while running and compares them with each item on the rsp channel.
// Depends on ddpd_pkg for the register indexes and the configuration port widths.

module ddpd_drive_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [15:0]                         req_right_counter,
   input  logic [15:0]                         req_left_counter,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [15:0]                  rsp_right_drive,
   input  logic signed [15:0]                  rsp_left_drive,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [ddpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ddpd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                  mismatches,
   output int                                  drives_pending,
   output int                                  drives_checked
);

   localparam int     REPORT_LIMIT = 10;
   localparam longint ERR_MAX      = 64'sd2147483647;
   localparam longint ERR_MIN      = -64'sd2147483648;
   localparam longint DRIVE_LIMIT  = 64'sd32767;

   typedef struct packed {
      logic signed [15:0] right_drive;
      logic signed [15:0] left_drive;
   } drive_pair_type;

   // settings as last written
   logic   running;
   longint aim_distance;
   longint aim_rotation;
   longint kp_trans;
   longint kd_trans;
   longint kp_rot;
   longint kd_rot;

   // controller state
   logic [15:0] last_right;
   logic [15:0] last_left;
   int          travel_right;
   int          travel_left;
   longint      last_trans_err;
   longint      last_rot_err;

   drive_pair_type expected_drives[$];
   int             bad_count = 0;
   int             seen_count = 0;

   function automatic longint limit_error(input longint v);
      if (v > ERR_MAX) return ERR_MAX;
      if (v < ERR_MIN) return ERR_MIN;
      return v;
   endfunction

   function automatic logic signed [15:0] limit_drive(input longint v);
      longint held;
      held = (v > DRIVE_LIMIT) ? DRIVE_LIMIT : ((v < -DRIVE_LIMIT) ? -DRIVE_LIMIT : v);
      return held[15:0];
   endfunction

   // Advance wheel state by one tick and work out the drive pair it commands
   function automatic drive_pair_type advance_controller(input logic [15:0] right_now,
                                                         input logic [15:0] left_now);
      logic [15:0]    right_raw;
      logic [15:0]    left_raw;
      shortint        right_step;
      shortint        left_step;
      longint         half_travel;
      longint         trans_err;
      longint         rot_err;
      longint         trans_fix;
      longint         rot_fix;
      drive_pair_type drives;
      // wrapped deltas against the previous readings
      right_raw = right_now - last_right;
      left_raw = left_now - last_left;
      right_step = $signed(right_raw);
      left_step = $signed(left_raw);
      last_right = right_now;
      last_left = left_now;
      // totals wrap at 32 bits
      travel_right = travel_right + right_step;
      travel_left = travel_left + left_step;
      half_travel = (longint'(travel_right) + longint'(travel_left)) >>> 1;
      trans_err = limit_error(aim_distance - half_travel);
      rot_err = limit_error(aim_rotation - (longint'(right_step) - longint'(left_step)));
      // PD law, Q8.8 gains, floor on the shift
      trans_fix = (kp_trans * trans_err + kd_trans * (trans_err - last_trans_err))
                  >>> ddpd_pkg::GAIN_FRACTION_BITS;
      rot_fix = (kp_rot * rot_err + kd_rot * (rot_err - last_rot_err))
                >>> ddpd_pkg::GAIN_FRACTION_BITS;
      last_trans_err = trans_err;
      last_rot_err = rot_err;
      drives.right_drive = limit_drive(trans_fix + rot_fix);
      drives.left_drive = limit_drive(trans_fix - rot_fix);
      return drives;
   endfunction

   always @(posedge clock) begin
      drive_pair_type want;
      if (reset) begin
         running = 1'b0;
         aim_distance = 0;
         aim_rotation = 0;
         kp_trans = 0;
         kd_trans = 0;
         kp_rot = 0;
         kd_rot = 0;
         last_right = '0;
         last_left = '0;
         travel_right = 0;
         travel_left = 0;
         last_trans_err = 0;
         last_rot_err = 0;
         expected_drives.delete();
      end else begin
         // retire the oldest expected pair against the delivered item
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               bad_count++;
               if (bad_count <= REPORT_LIMIT) begin
                  $display("drive item with nothing expected: right %0d left %0d",
                           rsp_right_drive, rsp_left_drive);
               end
            end else begin
               want = expected_drives.pop_front();
               seen_count++;
               if (want.right_drive !== rsp_right_drive ||
                   want.left_drive !== rsp_left_drive) begin
                  bad_count++;
                  if (bad_count <= REPORT_LIMIT) begin
                     $display("mismatch item %0d: right exp %0d got %0d, left exp %0d got %0d",
                              seen_count, want.right_drive, rsp_right_drive,
                              want.left_drive, rsp_left_drive);
                  end
               end
            end
         end
         // a tick taken while stopped changes nothing; it sees the settings before this edge
         if (req_valid && req_ready && running) begin
            expected_drives.push_back(advance_controller(req_right_counter, req_left_counter));
         end
         // apply a register write; unused indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ddpd_pkg::CSR_ENABLE:
                  running = csr_data[0];
               ddpd_pkg::CSR_TARGET_DISTANCE:
                  aim_distance = longint'($signed(csr_data[23:0]));
               ddpd_pkg::CSR_TARGET_ROTATION:
                  aim_rotation = longint'($signed(csr_data[15:0]));
               ddpd_pkg::CSR_KP_TRANSLATION:
                  kp_trans = longint'($signed(csr_data[15:0]));
               ddpd_pkg::CSR_KD_TRANSLATION:
                  kd_trans = longint'($signed(csr_data[15:0]));
               ddpd_pkg::CSR_KP_ROTATION:
                  kp_rot = longint'($signed(csr_data[15:0]));
               ddpd_pkg::CSR_KD_ROTATION:
                  kd_rot = longint'($signed(csr_data[15:0]));
               default: ;
            endcase
         end
      end
      mismatches <= bad_count;
      drives_pending <= expected_drives.size();
      drives_checked <= seen_count;
   end

endmodule

[bench/tb_differential_drive_pd_controller.sv]
`timescale 1ns / 1ps
// Bench top for the differential drive PD controller: clock, reset, register and tick
// stimulus with random handshake gaps, a stall watchdog and the verdict.
// Depends on ddpd_pkg, the controller RTL and ddpd_drive_checker.

module tb_differential_drive_pd_controller;

   localparam int HALF_PERIOD   = 4;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int BURST_TICKS   = 46;
   localparam logic [ddpd_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [15:0]                         req_right_counter = '0;
   logic [15:0]                         req_left_counter = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [15:0]                  rsp_right_drive;
   logic signed [15:0]                  rsp_left_drive;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [ddpd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ddpd_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   int          send_idle_pct = 11;
   int          recv_stall_pct = 80;
   int          quiet_cycles = 0;
   int          ticks_run = 0;
   int          ticks_stopped = 0;
   int          setting_groups = 0;
   logic        running = 1'b0;
   logic [15:0] right_reading = '0;
   logic [15:0] left_reading = '0;
   int          mismatches;
   int          drives_pending;
   int          drives_checked;

   differential_drive_pd_controller DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_right_counter (req_right_counter),
      .req_left_counter  (req_left_counter),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_left_drive    (rsp_left_drive),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   ddpd_drive_checker drive_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_right_counter (req_right_counter),
      .req_left_counter  (req_left_counter),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_left_drive    (rsp_left_drive),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .drives_pending    (drives_pending),
      .drives_checked    (drives_checked)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Receiver: stall at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: end the run when no item moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles, %0d drive pairs outstanding",
                  QUIET_LIMIT, drives_pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int rand_signed(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // Mostly small wheel motion, sometimes a jump to anywhere or a half-range step
   function automatic logic [15:0] next_reading(input logic [15:0] last);
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 16'($urandom);
      if (pick == 1) return last + ($urandom_range(1) ? 16'h7FFF : 16'h8000);
      return last + 16'(rand_signed(300));
   endfunction

   // Offer one tick, idling beforehand at random; return once it is taken
   task automatic send_tick(input logic [15:0] right_now, input logic [15:0] left_now);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_right_counter <= right_now;
      req_left_counter <= left_now;
      right_reading = right_now;
      left_reading = left_now;
      if (running) ticks_run++;
      else ticks_stopped++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_tick();
      logic [15:0] right_now;
      logic [15:0] left_now;
      right_now = next_reading(right_reading);
      left_now = next_reading(left_reading);
      send_tick(right_now, left_now);
   endtask

   // Hold a register write until taken; valid stays up for a following write
   task automatic csr_put(input logic [ddpd_pkg::CSR_INDEX_BITS-1:0] index,
                          input logic [ddpd_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      if (index == ddpd_pkg::CSR_ENABLE) running = value[0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every expected pair, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (drives_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [23:0] enable_word, input logic [23:0] distance,
                                 input logic [23:0] rotation, input logic [23:0] kp_t,
                                 input logic [23:0] kd_t, input logic [23:0] kp_r,
                                 input logic [23:0] kd_r);
      csr_put(ddpd_pkg::CSR_ENABLE, enable_word);
      csr_put(ddpd_pkg::CSR_TARGET_DISTANCE, distance);
      csr_put(ddpd_pkg::CSR_TARGET_ROTATION, rotation);
      csr_put(ddpd_pkg::CSR_KP_TRANSLATION, kp_t);
      csr_put(ddpd_pkg::CSR_KD_TRANSLATION, kd_t);
      csr_put(ddpd_pkg::CSR_KP_ROTATION, kp_r);
      csr_put(ddpd_pkg::CSR_KD_ROTATION, kd_r);
      // an unused index must leave everything as it was
      csr_put(CSR_UNUSED, 24'($urandom));
      csr_release();
      setting_groups++;
   endtask

   // Mild settings keep the drives mostly inside their range; wild ones span everything
   task automatic random_settings(input bit wild, input bit enable_bit);
      int gain_span;
      int rot_span;
      logic [23:0] distance;
      gain_span = wild ? 32768 : 600;
      rot_span = wild ? 32768 : 200;
      distance = wild ? 24'($urandom) : 24'(rand_signed(4000));
      write_settings({23'($urandom), enable_bit}, distance,
                     {8'($urandom), 16'(rand_signed(rot_span))},
                     {8'($urandom), 16'(rand_signed(gain_span))},
                     {8'($urandom), 16'(rand_signed(gain_span))},
                     {8'($urandom), 16'(rand_signed(gain_span))},
                     {8'($urandom), 16'(rand_signed(gain_span))});
   endtask

   initial begin : stimulus
      int phase;
      int burst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // stopped after reset: ticks are taken without a result
      send_tick(16'h1234, 16'hFEDC);
      send_tick(16'hFFFF, 16'h0000);
      settle();

      // unit gains, zero targets: counter wrap in both directions
      write_settings(24'd1, 24'd0, 24'd0, 24'd256, 24'd0, 24'd256, 24'd0);
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h0001, 16'hFFFF);
      send_tick(16'h8000, 16'h7FFF);
      send_tick(16'h0000, 16'hFFFF);
      send_tick(16'hFFFF, 16'hFFFF);
      settle();

      // extreme targets and gains, one way round: drives saturate
      write_settings(24'hFFFFFF, 24'h7FFFFF, 24'hA58000, 24'h5A7FFF,
                     24'hFF8000, 24'h008000, 24'h3C7FFF);
      send_tick(16'h7FFF, 16'h8000);
      send_tick(16'hFFFF, 16'h0000);
      send_tick(16'hFFFF, 16'h0000);
      send_tick(16'h0000, 16'hFFFF);
      settle();

      // and the other way round
      write_settings(24'h000001, 24'h800000, 24'h007FFF, 24'h008000,
                     24'h007FFF, 24'h007FFF, 24'h008000);
      send_tick(16'h8000, 16'h8000);
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h7FFF, 16'hFFFF);
      send_tick(16'h0001, 16'h7FFE);
      settle();

      // stop, tick, restart: the first tick after restart uses the stored readings
      csr_put(ddpd_pkg::CSR_ENABLE, 24'hFFFFFE);
      csr_release();
      send_tick(16'h4000, 16'hC000);
      send_tick(16'hAAAA, 16'h5555);
      send_tick(16'h5555, 16'hAAAA);
      settle();
      csr_put(ddpd_pkg::CSR_ENABLE, 24'h000001);
      csr_release();
      send_tick(16'h0010, 16'hFFF0);
      send_tick(16'h0020, 16'hFFE0);
      send_tick(16'h0020, 16'hFFE0);

      // random part: three idling patterns, three settings each
      for (phase = 0; phase < 3; phase++) begin
         settle();
         send_idle_pct <= (phase == 0) ? 11 : ((phase == 1) ? 80 : 0);
         recv_stall_pct <= (phase == 0) ? 80 : ((phase == 1) ? 11 : 0);
         for (burst = 0; burst < 3; burst++) begin
            settle();
            random_settings($urandom_range(3) == 0, burst != 1);
            if (burst == 1) begin
               // a stretch while stopped before running again
               repeat (6) random_tick();
               settle();
               csr_put(ddpd_pkg::CSR_ENABLE, {23'($urandom), 1'b1});
               csr_release();
            end
            repeat (BURST_TICKS) random_tick();
         end
      end

      settle();
      $display("Covered %0d ticks while running and %0d while stopped, %0d setting groups",
               ticks_run, ticks_stopped, setting_groups);
      $display("Checked %0d drive pairs, %0d mismatches", drives_checked, mismatches);
      if (mismatches == 0 && drives_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
